>>> src/mspg_pkg.sv
// Shared types and constants for the multi-axis step pulse generator.
package mspg_pkg;

	// Channel count and counter width.
	localparam int NUM_CHANNELS = 4;
	localparam int COUNT_BITS   = 24;

	// Fixed widths of the word fields.
	localparam int OPCODE_BITS = 2;
	localparam int INDEX_BITS  = 2;
	localparam int FIELD_BITS  = 24;
	localparam int MASK_BITS   = 4;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [MASK_BITS-1:0]  mask_t;

	// Operation codes carried in the opcode field.
	typedef enum logic [OPCODE_BITS-1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_STOP = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	// Command from the top level to one channel, valid for one cycle.
	typedef struct packed {
		logic   tick;
		logic   load;
		logic   stop;
		count_t steps;
		count_t delay;
		count_t skip;
		logic   dir;
	} chan_cmd_t;

	// Status from one channel: pulse this cycle and next-state levels.
	typedef struct packed {
		logic pulse;
		logic run_d;
		logic dir_d;
	} chan_stat_t;

endpackage

>>> src/multi_axis_step_pulse_generator.sv
// Top level of the multi-axis step pulse generator: input stage, channels, result register.
//
//  Channel | Handshake                  | Fields
//  --------+----------------------------+------------------------------------------------
//  in      | in_valid / in_stall        | opcode, motor_index, step_count, step_delay,
//          |                            | skip_interval, direction
//  out     | out_valid / out_stall      | step_pulses, running_mask, direction_mask
//
// One word is accepted per cycle while in_stall is low. Its result word then passes from the
// input register through the channel update into the result register once the output can advance.
// The channel counters update in the same cycle that the result register loads.
// A stalled output holds the result and back-pressures the input register only.
// Reset (arst_n low) clears every channel to stopped, with all counters at zero.
module multi_axis_step_pulse_generator
	import mspg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [OPCODE_BITS-1:0] opcode,
	input  logic [INDEX_BITS-1:0]  motor_index,
	input  field_t                 step_count,
	input  field_t                 step_delay,
	input  field_t                 skip_interval,
	input  logic                   direction,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mask_t                  step_pulses,
	output mask_t                  running_mask,
	output mask_t                  direction_mask
);

	// Input stage.
	logic                  valid_s1;
	opcode_t               opcode_s1;
	logic [INDEX_BITS-1:0] motor_index_s1;
	field_t                step_count_s1;
	field_t                step_delay_s1;
	field_t                skip_interval_s1;
	logic                  direction_s1;

	logic advance;
	logic fire;
	logic s1_load;

	// Result register.
	logic  out_valid_q;
	mask_t step_pulses_q;
	mask_t running_mask_q;
	mask_t direction_mask_q;

	chan_cmd_t  cmd   [NUM_CHANNELS];
	chan_stat_t stat  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] pulse_vec;
	logic [NUM_CHANNELS-1:0] run_vec;
	logic [NUM_CHANNELS-1:0] dir_vec;
	mask_t pulse_mask;
	mask_t run_mask;
	mask_t dir_mask;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign s1_load  = !valid_s1 || advance;
	assign in_stall = !s1_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			opcode_s1        <= opcode_t'(opcode);
			motor_index_s1   <= motor_index;
			step_count_s1    <= step_count;
			step_delay_s1    <= step_delay;
			skip_interval_s1 <= skip_interval;
			direction_s1     <= direction;
		end
	end

	// Per-channel command decode and channel instances.
	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		always_comb begin
			cmd[c].tick  = fire && (opcode_s1 == OP_TICK);
			cmd[c].load  = fire && (opcode_s1 == OP_LOAD) && (int'(motor_index_s1) == c);
			cmd[c].stop  = fire && (opcode_s1 == OP_STOP);
			cmd[c].steps = count_t'(step_count_s1);
			cmd[c].delay = count_t'(step_delay_s1);
			cmd[c].skip  = count_t'(skip_interval_s1);
			cmd[c].dir   = direction_s1;
		end

		mspg_channel u_channel (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[c]),
			.stat   (stat[c])
		);

		assign pulse_vec[c] = stat[c].pulse;
		assign run_vec[c]   = stat[c].run_d;
		assign dir_vec[c]   = stat[c].dir_d;
	end

	// Only the low channel bits show in the result masks.
	for (genvar b = 0; b < MASK_BITS; b++) begin : g_mask
		if (b < NUM_CHANNELS) begin : g_used
			assign pulse_mask[b] = pulse_vec[b];
			assign run_mask[b]   = run_vec[b];
			assign dir_mask[b]   = dir_vec[b];
		end else begin : g_unused
			assign pulse_mask[b] = 1'b0;
			assign run_mask[b]   = 1'b0;
			assign dir_mask[b]   = 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			step_pulses_q    <= pulse_mask;
			running_mask_q   <= run_mask;
			direction_mask_q <= dir_mask;
		end
	end

	assign out_valid      = out_valid_q;
	assign step_pulses    = step_pulses_q;
	assign running_mask   = running_mask_q;
	assign direction_mask = direction_mask_q;

	// Only a tick word can produce step pulses.
	a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (opcode_s1 != OP_TICK) |=> step_pulses == '0)
		else $error("step pulse on a word that is not a tick");

	// A stop word leaves every channel stopped.
	a_stop_clears_running: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (opcode_s1 == OP_STOP) |=> running_mask == '0)
		else $error("channel still running after a stop word");

	// A channel that steps is still running afterwards.
	a_pulse_implies_running: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (step_pulses & ~running_mask) == '0)
		else $error("step pulse on a channel that is not running");

	// A word held in the input stage is neither lost nor altered.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(opcode_s1) && $stable(motor_index_s1))
		else $error("input stage word changed while held");

endmodule

>>> src/mspg_channel.sv
// One stepper channel: step, delay and skip counters with their update logic.
module mspg_channel
	import mspg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  chan_cmd_t  cmd,
	output chan_stat_t stat
);

	count_t steps_left_q;
	count_t delay_ticks_q;
	count_t delay_count_q;
	count_t skip_ticks_q;
	count_t skip_count_q;
	logic   running_q;
	logic   direction_q;

	count_t steps_left_d;
	count_t delay_ticks_d;
	count_t delay_count_d;
	count_t skip_ticks_d;
	count_t skip_count_d;
	logic   running_d;
	logic   direction_d;
	logic   pulse;

	count_t skip_inc;
	count_t delay_inc;
	logic   skip_on;

	assign skip_inc  = skip_count_q + count_t'(1);
	assign delay_inc = delay_count_q + count_t'(1);
	assign skip_on   = (skip_ticks_q > count_t'(1));

	// Next-state logic for a tick, a load or a stop.
	always_comb begin
		steps_left_d  = steps_left_q;
		delay_ticks_d = delay_ticks_q;
		delay_count_d = delay_count_q;
		skip_ticks_d  = skip_ticks_q;
		skip_count_d  = skip_count_q;
		running_d     = running_q;
		direction_d   = direction_q;
		pulse         = 1'b0;
		if (cmd.load) begin
			steps_left_d  = cmd.steps;
			delay_ticks_d = cmd.delay;
			skip_ticks_d  = cmd.skip;
			direction_d   = cmd.dir;
			delay_count_d = '0;
			skip_count_d  = '0;
			running_d     = 1'b1;
		end else if (cmd.stop) begin
			running_d = 1'b0;
		end else if (cmd.tick && running_q) begin
			if (skip_on) begin
				skip_count_d = skip_inc;
			end
			if (skip_on && (skip_inc >= skip_ticks_q)) begin
				// This tick is swallowed by the skip interval.
				skip_count_d = '0;
			end else if (delay_inc >= delay_ticks_q) begin
				delay_count_d = '0;
				if (steps_left_q != '0) begin
					steps_left_d = steps_left_q - count_t'(1);
					pulse        = 1'b1;
				end else begin
					running_d = 1'b0;
				end
			end else begin
				delay_count_d = delay_inc;
			end
		end
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_left_q  <= '0;
			delay_ticks_q <= '0;
			delay_count_q <= '0;
			skip_ticks_q  <= '0;
			skip_count_q  <= '0;
			running_q     <= 1'b0;
			direction_q   <= 1'b0;
		end else begin
			steps_left_q  <= steps_left_d;
			delay_ticks_q <= delay_ticks_d;
			delay_count_q <= delay_count_d;
			skip_ticks_q  <= skip_ticks_d;
			skip_count_q  <= skip_count_d;
			running_q     <= running_d;
			direction_q   <= direction_d;
		end
	end

	assign stat.pulse = pulse;
	assign stat.run_d = running_d;
	assign stat.dir_d = direction_d;

endmodule
